// File: rtl/core/bdpc_pkg.sv
// Shared types and constants for the button debounce and press classifier.
`default_nettype none

package bdpc_pkg;

  // Timestamp width; time differences wrap at this width
  localparam int TIME_W = 32;
  localparam int DUR_W  = 16;

  // Configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_SHORT    = 2'd1;
  localparam logic [1:0] REG_HOLD     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] DEBOUNCE_RST = 16'd15;
  localparam logic [15:0] SHORT_RST    = 16'd1000;
  localparam logic [31:0] HOLD_RST     = 32'd3000;

  // Configuration seen by the evaluation logic
  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] short_max_ms;
    logic [31:0] hold_timeout_ms;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [DUR_W-1:0] press_ms;
    logic             ev_timeout;
    logic             ev_release;
    logic             ev_short;
    logic             ev_press;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/bdpc_eval.sv
// Debounce state and press classification for one poll item per cycle while fire is high.
`default_nettype none

module bdpc_eval (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       fire,
  input  wire logic                       level,
  input  wire logic [bdpc_pkg::TIME_W-1:0] now_ms,
  input  wire bdpc_pkg::cfg_t             cfg,
  output bdpc_pkg::result_t               result
);

  logic                        filter_level_r;
  logic                        last_level_r;
  logic                        held_r;
  logic [bdpc_pkg::TIME_W-1:0] debounce_start_r;
  logic [bdpc_pkg::TIME_W-1:0] press_start_r;

  logic                        filter_level_nxt;
  logic                        last_level_nxt;
  logic                        held_nxt;
  logic [bdpc_pkg::TIME_W-1:0] debounce_start_nxt;
  logic [bdpc_pkg::TIME_W-1:0] press_start_nxt;

  logic                        changed;
  logic [bdpc_pkg::TIME_W-1:0] db_elapsed;
  logic [bdpc_pkg::TIME_W-1:0] press_elapsed;
  logic [bdpc_pkg::TIME_W-1:0] hold_elapsed;
  logic                        stable;
  logic                        edge_seen;
  logic                        press_edge;
  logic                        is_release;
  logic                        held_mid;
  logic                        timeout;
  logic [bdpc_pkg::DUR_W-1:0]  dur;

  // A level change restarts the debounce timer, so its elapsed time is zero
  assign changed    = (level != filter_level_r);
  assign db_elapsed = changed ? '0 : (now_ms - debounce_start_r);
  assign stable     = (db_elapsed >= bdpc_pkg::TIME_W'(cfg.debounce_ms));

  // Accepted edge against the last accepted level
  assign edge_seen  = stable && (level != last_level_r);
  assign press_edge = edge_seen && !level;
  assign is_release = edge_seen && level;

  // One subtractor serves both duration and hold check; a new press restarts at zero
  assign press_elapsed = now_ms - press_start_r;
  assign hold_elapsed  = press_edge ? '0 : press_elapsed;
  assign dur           = is_release ? press_elapsed[bdpc_pkg::DUR_W-1:0] : '0;

  // Hold flag after the edge, then timeout check
  assign held_mid = press_edge ? 1'b1 : (is_release ? 1'b0 : held_r);
  assign timeout  = stable && held_mid &&
                    (hold_elapsed >= bdpc_pkg::TIME_W'(cfg.hold_timeout_ms));

  always_comb begin
    result.ev_press   = press_edge;
    result.ev_release = is_release;
    result.ev_short   = is_release && (dur <= cfg.short_max_ms);
    result.ev_timeout = timeout;
    result.press_ms   = dur;
  end

  // Next state, applied only when an item is processed
  always_comb begin
    filter_level_nxt   = filter_level_r;
    debounce_start_nxt = debounce_start_r;
    last_level_nxt     = last_level_r;
    press_start_nxt    = press_start_r;
    held_nxt           = held_r;
    if (fire) begin
      filter_level_nxt = level;
      if (changed) begin
        debounce_start_nxt = now_ms;
      end
      if (edge_seen) begin
        last_level_nxt = level;
      end
      if (press_edge) begin
        press_start_nxt = now_ms;
      end
      held_nxt = held_mid && !timeout;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_level_r   <= 1'b1;
      last_level_r     <= 1'b1;
      held_r           <= 1'b0;
      debounce_start_r <= '0;
      press_start_r    <= '0;
    end else begin
      filter_level_r   <= filter_level_nxt;
      last_level_r     <= last_level_nxt;
      held_r           <= held_nxt;
      debounce_start_r <= debounce_start_nxt;
      press_start_r    <= press_start_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/button_debounce_press_classifier_unit.sv
// Top level: stream ports, configuration registers, input and result registers.
`default_nettype none

// Debounces an active-low button from polled items (pin level plus millisecond
// timestamp) and reports press, release, short-press and hold-timeout events,
// one result item per poll item. An item is registered on input, evaluated
// against the debounce state and written to the result register once that
// register is empty or taken, and a new item can be accepted every cycle while
// results are taken. The rate is set by the state update (two 32-bit subtract
// and compare paths); while a finished result waits for out_tready the input
// register can still take one item, after which in_tready stays low until the
// result is taken.
module button_debounce_press_classifier_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  // poll items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [0] ev_press, [1] ev_short, [2] ev_release,
                                       // [3] ev_timeout, [19:4] press_ms, [23:20] zero
);

  bdpc_pkg::cfg_t              cfg_r;
  logic                        s1_valid_r;
  logic                        s1_level_r;
  logic [bdpc_pkg::TIME_W-1:0] s1_now_r;
  logic                        out_valid_r;
  bdpc_pkg::result_t           out_data_r;

  logic                        advance;
  logic                        fire;
  bdpc_pkg::result_t           result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= bdpc_pkg::DEBOUNCE_RST;
      cfg_r.short_max_ms    <= bdpc_pkg::SHORT_RST;
      cfg_r.hold_timeout_ms <= bdpc_pkg::HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bdpc_pkg::REG_DEBOUNCE: cfg_r.debounce_ms     <= cfg_wdata[15:0];
        bdpc_pkg::REG_SHORT:    cfg_r.short_max_ms    <= cfg_wdata[15:0];
        bdpc_pkg::REG_HOLD:     cfg_r.hold_timeout_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: result register frees when empty or taken
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_level_r <= in_tdata[0];
      s1_now_r   <= in_tdata[bdpc_pkg::TIME_W:1];
    end
  end

  bdpc_eval u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .level  (s1_level_r),
    .now_ms (s1_now_r),
    .cfg    (cfg_r),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_data_r};

endmodule

`default_nettype wire

// File: rtl/core/bdpc_checker.sv
// Port-level checks for the button classifier, bound to the top level.
`default_nettype none

module bdpc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Press and release come from one accepted edge, never both
  a_one_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[2]))
    else $error("press and release in one item");

  // Short press only comes with a release
  a_short_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[2])
    else $error("short press without release");

  // Duration is zero unless a release is reported
  a_dur_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[19:4] == 16'd0)
    else $error("duration without release");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_bdpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the button debounce and press classifier.
`timescale 1ns / 1ps

module tb_top;
  import bdpc_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_addr;
  logic [31:0]       cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [39:0]       in_tdata;   // [0] pin_level, [32:1] now_ms, [39:33] zero
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;  // [0] ev_press, [1] ev_short, [2] ev_release,
                                 // [3] ev_timeout, [19:4] press_ms, [23:20] zero

  button_debounce_press_classifier_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed item table
  typedef struct {
    bit                is_reg;
    logic [1:0]        idx;
    logic [TIME_W-1:0] value;
    logic              pin;
    bit                typed;
    result_t           want;
  } script_row_t;

  localparam result_t EV_QUIET   = '0;
  localparam result_t EV_PRESS   = '{press_ms: '0, ev_timeout: 1'b0, ev_release: 1'b0,
                                     ev_short: 1'b0, ev_press: 1'b1};
  localparam result_t EV_TIMEOUT = '{press_ms: '0, ev_timeout: 1'b1, ev_release: 1'b0,
                                     ev_short: 1'b0, ev_press: 1'b0};

  localparam int PHASES     = 6;
  localparam int PHASE_POLL = 270;

  script_row_t       script[$];
  result_t           pending_events[$];
  int                n_mismatch  = 0;
  int                events_seen = 0;
  bit                calm        = 1'b0;

  // Debounce state and configuration tracked by the predictor
  logic              m_filter;
  logic              m_last;
  logic [TIME_W-1:0] m_db_start;
  logic [TIME_W-1:0] m_press_start;
  logic              m_held;
  logic [15:0]       c_debounce;
  logic [15:0]       c_short;
  logic [TIME_W-1:0] c_hold;

  // Events caused by one poll; advances the tracked state
  function automatic result_t classify_poll(input logic pin, input logic [TIME_W-1:0] stamp);
    result_t           r;
    logic [TIME_W-1:0] stable_for;
    logic [TIME_W-1:0] pressed_for;
    r = '0;
    if (pin != m_filter) begin
      m_filter   = pin;
      m_db_start = stamp;
    end
    stable_for = stamp - m_db_start;
    if (stable_for >= {16'd0, c_debounce}) begin
      if (m_filter != m_last) begin
        if (!m_filter) begin
          m_press_start = stamp;
          r.ev_press    = 1'b1;
          m_held        = 1'b1;
        end else begin
          pressed_for  = stamp - m_press_start;
          r.press_ms   = pressed_for[DUR_W-1:0];
          r.ev_short   = (r.press_ms <= c_short);
          r.ev_release = 1'b1;
          m_held       = 1'b0;
        end
        m_last = m_filter;
      end
      pressed_for = stamp - m_press_start;
      if (m_held && pressed_for >= c_hold) begin
        r.ev_timeout = 1'b1;
        m_held       = 1'b0;
      end
    end
    return r;
  endfunction

  // Next poll timestamp, biased toward the debounce, short and hold boundaries
  function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] cur,
                                                   input bit bouncing);
    logic [TIME_W-1:0] step;
    if (bouncing) return cur + $urandom_range(0, c_debounce / 2);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: step = $urandom_range(0, 2 * c_debounce + 2);
      4:          step = c_debounce + $urandom_range(0, 2) - 1;
      5:          step = $urandom_range(0, 2 * c_short + 2);
      6:          step = (c_hold > 32'h1000_0000) ? $urandom
                                                  : $urandom_range(0, 2 * c_hold + 2);
      7: begin
        case ($urandom_range(0, 3))
          0:       return m_press_start + c_short;
          1:       return m_press_start + c_short + 1;
          2:       return m_press_start + c_hold - 1;
          default: return m_press_start + c_hold;
        endcase
      end
      8:          step = $urandom;
      default:    step = '0;
    endcase
    return cur + step;
  endfunction

  function automatic void add_poll(input logic pin, input logic [TIME_W-1:0] stamp,
                                   input bit typed = 1'b0, input result_t want = '0);
    script.push_back('{is_reg: 1'b0, idx: '0, value: stamp, pin: pin,
                       typed: typed, want: want});
  endfunction

  function automatic void add_reg(input logic [1:0] idx, input logic [TIME_W-1:0] value);
    script.push_back('{is_reg: 1'b1, idx: idx, value: value, pin: 1'b1,
                       typed: 1'b0, want: '0});
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_mismatch++;
    $display("tb: mismatch on %s: got %0h, want %0h at %0t", what, got, want, $realtime);
  endtask

  // One poll item; returns the predicted events once it is accepted
  task automatic send_poll(input logic pin, input logic [TIME_W-1:0] stamp,
                           output result_t pred);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, stamp, pin};
    do @(posedge clk); while (!in_tready);
    pred = classify_poll(pin, stamp);
  endtask

  task automatic pause_source(input int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drain all results before touching configuration
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_DEBOUNCE: c_debounce = value[15:0];
      REG_SHORT:    c_short    = value[15:0];
      REG_HOLD:     c_hold     = value;
      default: ;
    endcase
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[19:0]);
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected item", {8'd0, out_tdata}, '0);
      end else begin
        want = pending_events.pop_front();
        if (got.ev_press != want.ev_press)
          report_mismatch("ev_press", {31'd0, got.ev_press}, {31'd0, want.ev_press});
        if (got.ev_short != want.ev_short)
          report_mismatch("ev_short", {31'd0, got.ev_short}, {31'd0, want.ev_short});
        if (got.ev_release != want.ev_release)
          report_mismatch("ev_release", {31'd0, got.ev_release},
                          {31'd0, want.ev_release});
        if (got.ev_timeout != want.ev_timeout)
          report_mismatch("ev_timeout", {31'd0, got.ev_timeout},
                          {31'd0, want.ev_timeout});
        if (got.press_ms != want.press_ms)
          report_mismatch("press_ms", {16'd0, got.press_ms}, {16'd0, want.press_ms});
      end
      events_seen++;
    end
  end

  // Result side: random stall bursts plus one long hold-off
  initial begin : drive_sink
    int gap;
    bit gappy;
    bit held_back;
    gappy      = 1'b0;
    held_back  = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) gappy = !gappy;
      if (!held_back && events_seen >= 400) begin
        // hold off long enough for the block to back up into its input
        held_back = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end else if (!calm && gappy && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 16);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin : drive_source
    result_t           pred;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] hld;
    logic [31:0]       junk;
    logic [15:0]       dbn;
    logic [15:0]       shrt;
    logic              lvl;
    logic              pin;
    bit                src_gappy;
    int                sent;
    int                bounces;
    int                polls;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    src_gappy = 1'b0;

    m_filter      = 1'b1;
    m_last        = 1'b1;
    m_db_start    = '0;
    m_press_start = '0;
    m_held        = 1'b0;
    c_debounce    = DEBOUNCE_RST;
    c_short       = SHORT_RST;
    c_hold        = HOLD_RST;

    // Reset values: quiet start, debounced press, hold timeout, long release
    add_poll(1'b1, 32'd0,    1'b1, EV_QUIET);
    add_poll(1'b0, 32'd100,  1'b1, EV_QUIET);
    add_poll(1'b0, 32'd115,  1'b1, EV_PRESS);
    add_poll(1'b0, 32'd3115, 1'b1, EV_TIMEOUT);
    add_poll(1'b1, 32'd3200);
    add_poll(1'b1, 32'd3215, 1'b1, '{press_ms: 16'd3100, ev_timeout: 1'b0,
                                     ev_release: 1'b1, ev_short: 1'b0, ev_press: 1'b0});
    // release exactly at the short limit
    add_poll(1'b0, 32'd4000);
    add_poll(1'b0, 32'd4015, 1'b1, EV_PRESS);
    add_poll(1'b1, 32'd5000);
    add_poll(1'b1, 32'd5015, 1'b1, '{press_ms: 16'd1000, ev_timeout: 1'b0,
                                     ev_release: 1'b1, ev_short: 1'b1, ev_press: 1'b0});
    // contact bounce before a press
    add_poll(1'b0, 32'd6000);
    add_poll(1'b1, 32'd6005);
    add_poll(1'b0, 32'd6010);
    add_poll(1'b0, 32'd6025, 1'b1, EV_PRESS);
    // timestamp wraps during the release debounce
    add_poll(1'b1, 32'hFFFF_FFF0);
    add_poll(1'b1, 32'h0000_0000);
    // no timeout while the level is still bouncing
    add_reg(REG_HOLD, 32'd100);
    add_poll(1'b0, 32'd100);
    add_poll(1'b0, 32'd115);
    add_poll(1'b1, 32'd300);
    add_poll(1'b0, 32'd301);
    add_poll(1'b0, 32'd316);
    // zero debounce, zero short limit, zero hold timeout
    add_reg(REG_DEBOUNCE, 32'd0);
    add_reg(REG_SHORT, 32'd0);
    add_reg(REG_HOLD, 32'd0);
    add_poll(1'b1, 32'd400);
    add_poll(1'b0, 32'd401);
    add_poll(1'b1, 32'd401);
    // largest settings
    add_reg(REG_DEBOUNCE, 32'hFFFF_FFFF);
    add_reg(REG_SHORT, 32'h0000_FFFF);
    add_reg(REG_HOLD, 32'hFFFF_FFFF);
    add_poll(1'b0, 32'd1000);
    add_poll(1'b0, 32'd66535);
    add_poll(1'b1, 32'd200000);
    add_poll(1'b1, 32'hFFFF_FFFF);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (script[i]) begin
      if (script[i].is_reg) begin
        wait_idle();
        write_reg(script[i].idx, script[i].value);
      end else begin
        send_poll(script[i].pin, script[i].value, pred);
        pending_events.push_back(script[i].typed ? script[i].want : pred);
      end
    end

    // Random part: press and release gestures with bounce and some noise
    stamp = 32'd500000;
    lvl   = m_filter;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          dbn  = 16'($urandom_range(0, 30));
          shrt = 16'($urandom_range(0, 2000));
          hld  = $urandom_range(0, 6000);
        end
        1: begin
          dbn  = '0;
          shrt = '0;
          hld  = '0;
        end
        2: begin
          dbn  = 16'hFFFF;
          shrt = 16'hFFFF;
          hld  = 32'hFFFF_FFFF;
        end
        3: begin
          dbn  = 16'($urandom_range(0, 5));
          shrt = 16'($urandom);
          hld  = $urandom;
        end
        default: begin
          dbn  = 16'($urandom_range(0, 20));
          shrt = 16'($urandom_range(0, 300));
          hld  = $urandom_range(0, 800);
        end
      endcase
      junk = $urandom;
      write_reg(REG_DEBOUNCE, {junk[31:16], dbn});
      write_reg(REG_SHORT, {junk[15:0], shrt});
      write_reg(REG_HOLD, hld);
      calm = (ph == PHASES - 1);

      sent = 0;
      while (sent < PHASE_POLL) begin
        lvl     = !lvl;
        bounces = $urandom_range(0, 3);
        polls   = bounces + $urandom_range(1, 6);
        for (int k = 0; k < polls; k++) begin
          pin = (k < bounces && k % 2 == 1) ? !lvl : lvl;
          if ($urandom_range(0, 9) == 0) pin = 1'($urandom_range(0, 1));
          stamp = next_stamp(stamp, k < bounces);
          if ($urandom_range(0, 39) == 0) src_gappy = !src_gappy;
          if (!calm && src_gappy && $urandom_range(0, 2) == 0)
            pause_source($urandom_range(1, 16));
          send_poll(pin, stamp, pred);
          pending_events.push_back(pred);
          sent++;
        end
      end
    end

    // Drain and finish
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bdpc_pkg.sv
rtl/core/bdpc_eval.sv
rtl/core/button_debounce_press_classifier_unit.sv
rtl/core/bdpc_checker.sv
tb/tb_top.sv
